### src/dfe_pkg.sv
// Shared types, constants and helpers for the delimited frame extractor.
`default_nettype none
package dfe_pkg;

    // Frame buffer and marker geometry
    localparam int BUFFER_BYTES = 256;
    localparam int START_LEN    = 8;
    localparam int END_LEN      = 6;

    localparam int FILL_W      = $clog2(BUFFER_BYTES + 1);
    localparam int START_POS_W = 3;
    localparam int END_POS_W   = 3;
    localparam int POS_W       = 8;
    localparam int LEN_W       = 9;

    localparam int START_MARKER_W = 64;
    localparam int END_MARKER_W   = 48;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_INDEX_W    = 1;

    // Register indexes on the config port
    localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER   = 1'd1;

    // Reset values: "42START[" and "]42END", first character in the low byte
    localparam logic [START_MARKER_W-1:0] START_MARKER_RST = 64'h5B54524154533234;
    localparam logic [END_MARKER_W-1:0]   END_MARKER_RST   = 48'h444E4532345D;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_START  = 2'd1,
        PH_BODY   = 2'd2,
        PH_END    = 2'd3
    } phase_t;

    // One result beat
    typedef struct packed {
        logic             store_valid;
        logic [POS_W-1:0] store_pos;
        logic [7:0]       store_data;
        logic             frame_done;
        logic [LEN_W-1:0] frame_len;
        logic             frame_dropped;
        logic             overflow;
    } result_t;

    // Byte k of a marker word
    function automatic logic [7:0] marker_byte(input logic [63:0] m, input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = m[7:0];
            3'd1:    b = m[15:8];
            3'd2:    b = m[23:16];
            3'd3:    b = m[31:24];
            3'd4:    b = m[39:32];
            3'd5:    b = m[47:40];
            3'd6:    b = m[55:48];
            3'd7:    b = m[63:56];
            default: b = m[7:0];
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

### src/dfe_cfg.sv
// Marker configuration registers.
`default_nettype none
module dfe_cfg (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [dfe_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [dfe_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic      [dfe_pkg::START_MARKER_W-1:0]   start_marker,
    output logic      [dfe_pkg::END_MARKER_W-1:0]     end_marker
);

    logic [dfe_pkg::START_MARKER_W-1:0] start_marker_reg;
    logic [dfe_pkg::END_MARKER_W-1:0]   end_marker_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= dfe_pkg::START_MARKER_RST;
            end_marker_reg   <= dfe_pkg::END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dfe_pkg::REG_START_MARKER:
                    start_marker_reg <= cfg_data[dfe_pkg::START_MARKER_W-1:0];
                dfe_pkg::REG_END_MARKER:
                    end_marker_reg <= cfg_data[dfe_pkg::END_MARKER_W-1:0];
                default:
                    start_marker_reg <= start_marker_reg;
            endcase
        end
    end

    assign start_marker = start_marker_reg;
    assign end_marker   = end_marker_reg;

endmodule
`default_nettype wire

### src/dfe_deframer.sv
// Deframing state machine: marker matching, fill count and per-byte result.
`default_nettype none
module dfe_deframer (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 proc,
    input  wire logic [7:0]                           rx_byte,
    input  wire logic [dfe_pkg::START_MARKER_W-1:0]   start_marker,
    input  wire logic [dfe_pkg::END_MARKER_W-1:0]     end_marker,
    output dfe_pkg::result_t                          result
);

    dfe_pkg::phase_t                  phase_reg, phase_next;
    logic [dfe_pkg::START_POS_W-1:0]  start_pos_reg, start_pos_next;
    logic [dfe_pkg::END_POS_W-1:0]    end_pos_reg, end_pos_next;
    logic [dfe_pkg::FILL_W-1:0]       fill_count_reg, fill_count_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= dfe_pkg::PH_SEARCH;
            start_pos_reg  <= '0;
            end_pos_reg    <= '0;
            fill_count_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            start_pos_reg  <= start_pos_next;
            end_pos_reg    <= end_pos_next;
            fill_count_reg <= fill_count_next;
        end
    end

    // Next state and result
    always_comb
    begin
        logic [7:0]                       sbyte;
        logic [7:0]                       ebyte;
        logic                             store;
        logic                             done;
        logic                             dropped;
        logic                             ovf;
        logic                             start_last;
        logic                             end_last;
        logic [dfe_pkg::FILL_W-1:0]       fill_inc;
        dfe_pkg::phase_t                  np;
        logic [dfe_pkg::START_POS_W-1:0]  ns;
        logic [dfe_pkg::END_POS_W-1:0]    ne;

        sbyte      = dfe_pkg::marker_byte(start_marker, start_pos_reg);
        ebyte      = dfe_pkg::marker_byte({16'd0, end_marker}, end_pos_reg);
        start_last = start_pos_reg >= dfe_pkg::START_POS_W'(dfe_pkg::START_LEN - 1);
        end_last   = end_pos_reg >= dfe_pkg::END_POS_W'(dfe_pkg::END_LEN - 1);
        fill_inc   = fill_count_reg + 1'b1;
        store      = 1'b0;
        done       = 1'b0;
        dropped    = 1'b0;
        ovf        = 1'b0;
        np         = phase_reg;
        ns         = start_pos_reg;
        ne         = end_pos_reg;

        phase_next      = phase_reg;
        start_pos_next  = start_pos_reg;
        end_pos_next    = end_pos_reg;
        fill_count_next = fill_count_reg;

        if (proc && rx_byte != 8'd0)
        begin
            case (phase_reg)
                dfe_pkg::PH_SEARCH, dfe_pkg::PH_START:
                begin
                    if (rx_byte == sbyte)
                    begin
                        store = 1'b1;
                        if (start_last)
                        begin
                            np = dfe_pkg::PH_BODY;
                            ns = '0;
                        end
                        else
                        begin
                            np = dfe_pkg::PH_START;
                            ns = start_pos_reg + 1'b1;
                        end
                    end
                    else if (phase_reg == dfe_pkg::PH_START)
                    begin
                        dropped = 1'b1;
                    end
                end
                dfe_pkg::PH_BODY:
                begin
                    store = 1'b1;
                    if (rx_byte == ebyte)
                    begin
                        if (end_last)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            np = dfe_pkg::PH_END;
                            ne = end_pos_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    // end marker in progress: any mismatch abandons the frame
                    if (rx_byte == ebyte)
                    begin
                        store = 1'b1;
                        if (end_last)
                            done = 1'b1;
                        else
                            ne = end_pos_reg + 1'b1;
                    end
                    else
                    begin
                        dropped = 1'b1;
                    end
                end
            endcase

            // buffer full: byte is not stored, frame dropped
            if (store && fill_count_reg >= dfe_pkg::FILL_W'(dfe_pkg::BUFFER_BYTES))
            begin
                store = 1'b0;
                done  = 1'b0;
                ovf   = 1'b1;
            end

            if (dropped || ovf || (store && done))
            begin
                phase_next      = dfe_pkg::PH_SEARCH;
                start_pos_next  = '0;
                end_pos_next    = '0;
                fill_count_next = '0;
            end
            else if (store)
            begin
                phase_next      = np;
                start_pos_next  = ns;
                end_pos_next    = ne;
                fill_count_next = fill_inc;
            end
        end

        result.store_valid   = store;
        result.store_pos     = store ? fill_count_reg[dfe_pkg::POS_W-1:0] : '0;
        result.store_data    = store ? rx_byte : 8'd0;
        result.frame_done    = done;
        result.frame_len     = done ? dfe_pkg::LEN_W'(fill_inc) : '0;
        result.frame_dropped = dropped;
        result.overflow      = ovf;
    end

endmodule
`default_nettype wire

### src/delimited_frame_extractor.sv
// Top level of the delimited frame extractor: stream ports, beat registers, assertions.
`default_nettype none
// Takes one received byte per input beat and returns exactly one result beat for it.
// Zero bytes are ignored (all-zero result). The block hunts for the 8-byte start marker,
// then passes every frame byte, markers included, out with its buffer position until the
// 6-byte end marker completes; the completing beat carries tlast and the frame length.
// A marker mismatch drops the frame (frame_dropped), as does a frame longer than
// 256 bytes (overflow). Throughput is one byte per clock unless m_tready stalls output;
// each beat is held in the input register, then the result register, with the marker
// compare and fill count update between them. Marker registers must be written through
// the config port only while the stream is idle; the block does not enforce this.
module delimited_frame_extractor (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // config write port
    input  wire logic                                cfg_we,
    input  wire logic [dfe_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [dfe_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,  // [7:0] rx_byte
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [0] store_valid, [8:1] store_pos, [16:9] store_data, [25:17] frame_len,
    // [26] frame_dropped, [27] overflow, [31:28] zero
    output logic [31:0]                              m_tdata,
    output logic                                     m_tlast   // frame_done
);

    logic [dfe_pkg::START_MARKER_W-1:0] start_marker;
    logic [dfe_pkg::END_MARKER_W-1:0]   end_marker;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    dfe_pkg::result_t out_reg;
    dfe_pkg::result_t result;
    logic             advance;
    logic             proc;

    dfe_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start_marker (start_marker),
        .end_marker   (end_marker)
    );

    // Pipeline moves when the result register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign proc     = in_valid_reg && advance;

    dfe_deframer u_deframer (
        .clk          (clk),
        .rst_n        (rst_n),
        .proc         (proc),
        .rx_byte      (in_byte_reg),
        .start_marker (start_marker),
        .end_marker   (end_marker),
        .result       (result)
    );

    // Input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    // Result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (proc)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.frame_done;
    assign m_tdata  = {4'd0,
                       out_reg.overflow,
                       out_reg.frame_dropped,
                       out_reg.frame_len,
                       out_reg.store_data,
                       out_reg.store_pos,
                       out_reg.store_valid};

    // A completed frame always stores its final byte
    a_done_stores: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[0])
        else $error("frame_done without store_valid");

    // Drop and overflow are exclusive, and neither stores a byte
    a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[26] || m_tdata[27]) |-> !m_tdata[0] && !m_tlast
            && !(m_tdata[26] && m_tdata[27]))
        else $error("drop or overflow beat carries other events");

    // An input beat accepted while the input register is empty is loaded into that register
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !in_valid_reg |=> in_valid_reg)
        else $error("accepted input beat lost");

endmodule
`default_nettype wire

### tb/sv/tb_delimited_frame_extractor.sv
// Self-checking testbench for the delimited frame extractor: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_delimited_frame_extractor;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AT      = 500;   // result count that triggers the long back-pressure
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        logic [7:0]       rx;
        bit               typed;   // want holds a hand-written expectation
        dfe_pkg::result_t want;
    } rx_item_t;

    // Directed row: input byte, whether the expectation is typed in, expectation
    typedef struct packed {
        logic [7:0]       rx;
        logic             typed;
        dfe_pkg::result_t want;
    } dir_row_t;

    localparam dfe_pkg::result_t NO_RESULT     = '0;
    localparam dfe_pkg::result_t R_FIRST_START =
        '{1'b1, 8'd0, 8'h34, 1'b0, 9'd0, 1'b0, 1'b0};
    localparam dfe_pkg::result_t R_END_MISS    =
        '{1'b0, 8'd0, 8'h00, 1'b0, 9'd0, 1'b1, 1'b0};
    localparam dfe_pkg::result_t R_FRAME_DONE  =
        '{1'b1, 8'd14, 8'h44, 1'b1, 9'd15, 1'b0, 1'b0};

    // Directed rows on the reset markers "42START[" / "]42END"
    localparam int DIR_ROWS = 28;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{8'h00, 1'b1, NO_RESULT},       // zero byte ignored
        '{8'hFF, 1'b1, NO_RESULT},       // discarded in search
        '{8'h34, 1'b1, R_FIRST_START},   // first start byte
        '{8'h32, 1'b0, NO_RESULT},
        '{8'h53, 1'b0, NO_RESULT},
        '{8'h54, 1'b0, NO_RESULT},
        '{8'h41, 1'b0, NO_RESULT},
        '{8'h52, 1'b0, NO_RESULT},
        '{8'h54, 1'b0, NO_RESULT},
        '{8'h5B, 1'b0, NO_RESULT},
        '{8'h5D, 1'b0, NO_RESULT},       // body opens end marker
        '{8'h34, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, R_END_MISS},      // miss in end marker
        '{8'h34, 1'b0, NO_RESULT},
        '{8'h32, 1'b0, NO_RESULT},
        '{8'h53, 1'b0, NO_RESULT},
        '{8'h54, 1'b0, NO_RESULT},
        '{8'h41, 1'b0, NO_RESULT},
        '{8'h52, 1'b0, NO_RESULT},
        '{8'h54, 1'b0, NO_RESULT},
        '{8'h5B, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'h5D, 1'b0, NO_RESULT},
        '{8'h34, 1'b0, NO_RESULT},
        '{8'h32, 1'b0, NO_RESULT},
        '{8'h45, 1'b0, NO_RESULT},
        '{8'h4E, 1'b0, NO_RESULT},
        '{8'h44, 1'b1, R_FRAME_DONE}     // frame complete
    };

    // DUT ports
    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [dfe_pkg::CFG_INDEX_W-1:0] cfg_index = dfe_pkg::REG_START_MARKER;
    logic [dfe_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata   = 8'h00;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [31:0]                     m_tdata;
    logic                            m_tlast;

    // Deframer mirror: configuration and frame state
    logic [dfe_pkg::START_MARKER_W-1:0] start_mark = dfe_pkg::START_MARKER_RST;
    logic [dfe_pkg::END_MARKER_W-1:0]   end_mark   = dfe_pkg::END_MARKER_RST;
    dfe_pkg::phase_t                    ph         = dfe_pkg::PH_SEARCH;
    logic [dfe_pkg::START_POS_W-1:0]    st_idx     = '0;
    logic [dfe_pkg::END_POS_W-1:0]      en_idx     = '0;
    logic [dfe_pkg::FILL_W-1:0]         fill       = '0;

    // Stimulus and result bookkeeping
    rx_item_t          byte_q[$];
    rx_item_t          offer;
    dfe_pkg::result_t  frame_results[$];
    dfe_pkg::result_t  predicted;
    int                beats_in_flight = 0;
    int                items_queued    = 0;
    int                tx_gap          = 0;
    int                rx_stall        = 0;
    int                results_seen    = 0;
    bit                hold_done       = 1'b0;
    bit                gaps_on         = 1'b1;
    int                fails           = 0;
    int                cycles          = 0;

    delimited_frame_extractor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] start_byte(input int k);
        return start_mark[k*8 +: 8];
    endfunction

    function automatic logic [7:0] end_byte(input int k);
        return end_mark[k*8 +: 8];
    endfunction

    function automatic void clear_frame();
        ph     = dfe_pkg::PH_SEARCH;
        st_idx = '0;
        en_idx = '0;
        fill   = '0;
    endfunction

    // Advance the mirror by one received byte and return the result beat it yields
    function automatic dfe_pkg::result_t deframe_byte(input logic [7:0] b);
        dfe_pkg::result_t                r;
        logic                            keep;
        logic                            done;
        logic                            drop;
        logic                            ovf;
        dfe_pkg::phase_t                 nph;
        logic [dfe_pkg::START_POS_W-1:0] nst;
        logic [dfe_pkg::END_POS_W-1:0]   nen;
        r    = '0;
        keep = 1'b0;
        done = 1'b0;
        drop = 1'b0;
        ovf  = 1'b0;
        nph  = ph;
        nst  = st_idx;
        nen  = en_idx;
        if (b != 8'h00)
        begin
            case (ph)
                dfe_pkg::PH_SEARCH, dfe_pkg::PH_START:
                begin
                    if (b == start_byte(int'(st_idx)))
                    begin
                        keep = 1'b1;
                        if (st_idx == dfe_pkg::START_POS_W'(dfe_pkg::START_LEN - 1))
                        begin
                            nph = dfe_pkg::PH_BODY;
                            nst = '0;
                        end
                        else
                        begin
                            nph = dfe_pkg::PH_START;
                            nst = st_idx + 1'b1;
                        end
                    end
                    else if (ph == dfe_pkg::PH_START)
                        drop = 1'b1;
                end
                dfe_pkg::PH_BODY:
                begin
                    keep = 1'b1;
                    if (b == end_byte(int'(en_idx)))
                    begin
                        if (en_idx == dfe_pkg::END_POS_W'(dfe_pkg::END_LEN - 1))
                            done = 1'b1;
                        else
                        begin
                            nph = dfe_pkg::PH_END;
                            nen = en_idx + 1'b1;
                        end
                    end
                end
                default:
                begin
                    // once inside the end marker, any miss drops the frame
                    if (b == end_byte(int'(en_idx)))
                    begin
                        keep = 1'b1;
                        if (en_idx == dfe_pkg::END_POS_W'(dfe_pkg::END_LEN - 1))
                            done = 1'b1;
                        else
                            nen = en_idx + 1'b1;
                    end
                    else
                        drop = 1'b1;
                end
            endcase

            // buffer full: the byte is refused and the frame abandoned
            if (keep && fill >= dfe_pkg::FILL_W'(dfe_pkg::BUFFER_BYTES))
            begin
                keep = 1'b0;
                done = 1'b0;
                ovf  = 1'b1;
            end

            if (drop || ovf)
                clear_frame();
            else if (keep)
            begin
                r.store_pos = fill[dfe_pkg::POS_W-1:0];
                fill = fill + 1'b1;
                if (done)
                begin
                    r.frame_len = fill;
                    clear_frame();
                end
                else
                begin
                    ph     = nph;
                    st_idx = nst;
                    en_idx = nen;
                end
            end
            r.store_valid   = keep;
            r.store_data    = keep ? b : 8'h00;
            r.frame_done    = done;
            r.frame_dropped = drop;
            r.overflow      = ovf;
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] other_byte(input logic [7:0] good);
        logic [7:0] b;
        b = good;
        while (b == good || b == 8'h00)
            b = 8'($urandom_range(1, 255));
        return b;
    endfunction

    // Body filler that does not open an end marker by accident
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        while (b == end_byte(0))
            b = 8'($urandom_range(1, 255));
        return b;
    endfunction

    function automatic logic [63:0] rand_marker();
        logic [63:0] m;
        for (int k = 0; k < 8; k++)
            m[k*8 +: 8] = 8'($urandom_range(1, 255));
        return m;
    endfunction

    task automatic push_item(input logic [7:0] b, input bit typed,
                             input dfe_pkg::result_t want);
        rx_item_t t;
        t.rx    = b;
        t.typed = typed;
        t.want  = want;
        byte_q.push_back(t);
        beats_in_flight++;
        if (b != 8'h00)
            items_queued++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_item(b, 1'b0, '0);
    endtask

    // Mostly well-formed frames with random bodies; some noise and broken starts
    task automatic queue_traffic(input int n, input int first_len);
        int goal;
        int kind;
        int len;
        int bad;
        int r;
        int k;
        int j;
        int part;
        bit forced;
        goal   = items_queued + n;
        forced = (first_len >= 0);
        while (items_queued < goal)
        begin
            kind = forced ? 0 : $urandom_range(0, 99);
            if (kind < 70)
            begin
                bad = ($urandom_range(0, 9) == 0 && !forced) ?
                      $urandom_range(0, dfe_pkg::START_LEN + dfe_pkg::END_LEN - 1) : -1;
                if (forced)
                    len = first_len;
                else if ($urandom_range(0, 29) == 0)
                    len = $urandom_range(238, 250);
                else
                    len = $urandom_range(0, 24);
                forced = 1'b0;
                for (k = 0; k < dfe_pkg::START_LEN; k++)
                    push_byte(k == bad ? other_byte(start_byte(k)) : start_byte(k));
                for (k = 0; k < len; k++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 5)
                        push_byte(8'h00);
                    else if (r < 7 && len < 100)
                    begin
                        // partial end marker inside the body
                        part = $urandom_range(1, dfe_pkg::END_LEN - 1);
                        for (j = 0; j < part; j++)
                            push_byte(end_byte(j));
                    end
                    else
                        push_byte(body_byte());
                end
                for (k = 0; k < dfe_pkg::END_LEN; k++)
                    push_byte(k + dfe_pkg::START_LEN == bad ?
                              other_byte(end_byte(k)) : end_byte(k));
            end
            else if (kind < 88)
            begin
                repeat ($urandom_range(1, 12))
                    push_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                k = $urandom_range(1, dfe_pkg::START_LEN - 1);
                for (j = 0; j < k; j++)
                    push_byte(start_byte(j));
                push_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic wait_idle();
        while (beats_in_flight != 0 || frame_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Both marker registers, back to back; caller guarantees the block is idle
    task automatic write_markers(input logic [63:0] s, input logic [63:0] e);
        cfg_we    <= 1'b1;
        cfg_index <= dfe_pkg::REG_START_MARKER;
        cfg_data  <= s;
        @(posedge clk);
        cfg_index <= dfe_pkg::REG_END_MARKER;
        cfg_data  <= e;
        @(posedge clk);
        cfg_we    <= 1'b0;
        start_mark = s;
        end_mark   = e[dfe_pkg::END_MARKER_W-1:0];
    endtask

    task automatic run_phase(input logic [63:0] s, input logic [63:0] e, input bit gaps,
                             input int n, input int first_len);
        wait_idle();
        write_markers(s, e);
        gaps_on = gaps;
        queue_traffic(n, first_len);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // Input side: offer queued bytes, predict each accepted beat
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            predicted = deframe_byte(offer.rx);
            frame_results.push_back(offer.typed ? offer.want : predicted);
            beats_in_flight--;
        end
        if (!s_tvalid || s_tready)
        begin
            if (tx_gap > 0)
            begin
                s_tvalid <= 1'b0;
                tx_gap--;
            end
            else if (byte_q.size() != 0)
            begin
                offer = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= offer.rx;
                tx_gap = pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Output side: check each result beat, random stalls plus one long hold
    always @(posedge clk)
    begin
        dfe_pkg::result_t want;
        if (m_tvalid && m_tready)
        begin
            results_seen++;
            if (frame_results.size() == 0)
            begin
                $error("result beat with nothing expected: tdata=%h tlast=%b",
                       m_tdata, m_tlast);
                fails++;
            end
            else
            begin
                want = frame_results.pop_front();
                check_field("store_valid", 32'(want.store_valid), 32'(m_tdata[0]));
                check_field("store_pos", 32'(want.store_pos), 32'(m_tdata[8:1]));
                check_field("store_data", 32'(want.store_data), 32'(m_tdata[16:9]));
                check_field("frame_done", 32'(want.frame_done), 32'(m_tlast));
                check_field("frame_len", 32'(want.frame_len), 32'(m_tdata[25:17]));
                check_field("frame_dropped", 32'(want.frame_dropped), 32'(m_tdata[26]));
                check_field("overflow", 32'(want.overflow), 32'(m_tdata[27]));
            end
        end
        if (results_seen == HOLD_AT && !hold_done)
        begin
            rx_stall  = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall--;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_stall = pick_gap();
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < DIR_ROWS; i++)
            push_item(DIR_TABLE[i].rx, DIR_TABLE[i].typed, DIR_TABLE[i].want);

        // Random phases across marker settings
        run_phase(dfe_pkg::START_MARKER_RST, {16'h0000, dfe_pkg::END_MARKER_RST},
                  1'b1, 260, 250);
        run_phase({8{8'hFF}}, {16'hDEAD, {6{8'hFF}}}, 1'b0, 220, 242);
        run_phase({8{8'h01}}, {16'h0000, {6{8'h01}}}, 1'b1, 220, -1);
        repeat (3)
            run_phase(rand_marker(), rand_marker(), 1'b1, 240, -1);
        begin
            logic [63:0] holed;
            holed = rand_marker();
            holed[$urandom_range(0, dfe_pkg::START_LEN - 1)*8 +: 8] = 8'h00;
            run_phase(holed, rand_marker(), 1'b1, 150, -1);
        end
        run_phase('0, '0, 1'b1, 60, -1);
        run_phase(dfe_pkg::START_MARKER_RST, {16'h0000, dfe_pkg::END_MARKER_RST},
                  1'b1, 200, -1);

        wait_idle();
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
